[rtl/fmrpd_pkg.sv]
// shared constants, types and helpers for the four-motor ramp pwm drive
`timescale 1ns / 1ps

package fmrpd_pkg;

   localparam int NUM_MOTORS = 4;
   localparam int FRAC_BITS  = 8;
   localparam int DRV_W      = 16;
   localparam int MOT_W      = $clog2(NUM_MOTORS);
   localparam int BAL_W      = 7;
   localparam int DIV_W      = 8;
   localparam int DUTY_W     = 8;
   localparam int PCT_W      = 7;
   localparam int PROD_W     = DRV_W + BAL_W;
   localparam int CNT_W      = $clog2(DRV_W);
   localparam int CSR_IDX_W  = 3;

   localparam int PCT_FULL   = 100;
   localparam int PCT_MIN    = 15;
   localparam int DIV_RESET  = 10;

   localparam logic [DRV_W-1:0] MAG_FULL = DRV_W'(PCT_FULL << FRAC_BITS);
   localparam logic [DRV_W-1:0] MAG_LOW  = DRV_W'(PCT_MIN << FRAC_BITS);
   localparam logic [DRV_W-1:0] MAG_ONE  = DRV_W'(1 << FRAC_BITS);

   localparam logic [NUM_MOTORS-1:0] INVERT_MASK = NUM_MOTORS'(6);

   // floor(x * 255 / 100) as x * 255 * 5243 >> 19, exact for x up to 100
   localparam int DUTY_MUL   = 1336965;
   localparam int DUTY_SHIFT = 19;
   localparam int DUTY_PW    = 28;

   // floor(x / 100) as x * 5368710 >> 29, exact for any scaled drive magnitude
   localparam int RECIP_MUL   = 5368710;
   localparam int RECIP_SHIFT = 29;
   localparam int RECIP_PW    = RECIP_SHIFT + DRV_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RAMP_DIVISOR = 3'd0,
      CSR_BALANCE_ONE  = 3'd1,
      CSR_BALANCE_TWO  = 3'd2,
      CSR_BALANCE_THREE = 3'd3,
      CSR_BALANCE_FOUR = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ERR,
      ST_DIV,
      ST_SCALE,
      ST_RECIP,
      ST_SHAPE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic load_err;
      logic div_step;
      logic load_scale;
      logic recip;
      logic shape;
      logic finish;
   } ctrl_type;

   function automatic logic [DUTY_W-1:0] duty_of(input logic [PCT_W-1:0] pct);
      logic [DUTY_PW-1:0] p;
      p = DUTY_PW'(pct) * DUTY_PW'(DUTY_MUL);
      return p[DUTY_SHIFT+DUTY_W-1:DUTY_SHIFT];
   endfunction

   function automatic logic [DRV_W-1:0] div_by_pct(input logic [PROD_W-1:0] x);
      logic [RECIP_PW-1:0] p;
      p = RECIP_PW'(x) * RECIP_PW'(RECIP_MUL);
      return p[RECIP_PW-1:RECIP_SHIFT];
   endfunction

endpackage

[rtl/four_motor_ramp_pwm_drive.sv]
// top level: per-motor ramp, balance scaling, shaping and pwm duty over a shared divider
// rsp_valid rises from the DONE state, after every motor has passed through ST_ERR, ST_DIV,
//   ST_SCALE, ST_RECIP and ST_SHAPE; ST_DIV runs the restoring divider for the ramp step
// req_stall stays high outside ST_IDLE, so a new request beat waits until the last one is done
// reset: synchronous; drives clear to zero, ramp divisor to 10, balances to 100
// a new request is taken while the previous response beat still waits to be taken
`timescale 1ns / 1ps

module four_motor_ramp_pwm_drive (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [fmrpd_pkg::DRV_W-1:0] req_target_one,
   input  logic signed [fmrpd_pkg::DRV_W-1:0] req_target_two,
   input  logic signed [fmrpd_pkg::DRV_W-1:0] req_target_three,
   input  logic signed [fmrpd_pkg::DRV_W-1:0] req_target_four,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_dir_one,
   output logic [fmrpd_pkg::DUTY_W-1:0]      rsp_duty_one,
   output logic                              rsp_dir_two,
   output logic [fmrpd_pkg::DUTY_W-1:0]      rsp_duty_two,
   output logic                              rsp_dir_three,
   output logic [fmrpd_pkg::DUTY_W-1:0]      rsp_duty_three,
   output logic                              rsp_dir_four,
   output logic [fmrpd_pkg::DUTY_W-1:0]      rsp_duty_four,
   input  logic                              csr_wr_en,
   input  logic [fmrpd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fmrpd_pkg::DIV_W-1:0]       csr_wdata
);

   import fmrpd_pkg::*;

   state_type state_ff, state_in;
   ctrl_type  ctrl;

   logic [MOT_W-1:0]  motor_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              neg_ff;
   logic [DIV_W-1:0]  dsor_ff;
   logic [DIV_W-1:0]  rem_ff;
   logic [DRV_W-1:0]  quo_ff;
   logic [PROD_W-1:0] prod_ff;

   logic signed [DRV_W-1:0] target_ff [NUM_MOTORS];
   logic signed [DRV_W-1:0] drive_ff [NUM_MOTORS];
   logic [DIV_W-1:0]        ramp_div_ff;
   logic [BAL_W-1:0]        bal_ff [NUM_MOTORS];
   logic [NUM_MOTORS-1:0]   dir_ff;
   logic [DUTY_W-1:0]       duty_ff [NUM_MOTORS];

   logic                    rsp_valid_ff;
   logic [NUM_MOTORS-1:0]   rsp_dir_ff;
   logic [DUTY_W-1:0]       rsp_duty_ff [NUM_MOTORS];

   logic [BAL_W-1:0]        bal_wr;
   logic signed [DRV_W-1:0] cur_target, cur_drive;
   logic [DRV_W:0]          err;
   logic [DRV_W-1:0]        err_mag;
   logic [DIV_W-1:0]        div_eff;
   logic [DIV_W:0]          rem_sh;
   logic                    fits;
   logic [DIV_W-1:0]        rem_nx;
   logic [DRV_W:0]          delta;
   logic [DRV_W:0]          new_sum;
   logic [DRV_W-1:0]        new_drive;
   logic [DRV_W-1:0]        new_abs;
   logic [PROD_W-1:0]       product;
   logic [DRV_W-1:0]        mag_c, mag_s;
   logic                    neg_s;
   logic [DUTY_W-1:0]       duty_s;
   logic                    level_s;
   logic                    last_motor;
   logic                    last_step;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_ERR;
         ST_ERR:   state_in = ST_DIV;
         ST_DIV: begin
            if (last_step) state_in = ST_SCALE;
         end
         ST_SCALE: state_in = ST_RECIP;
         ST_RECIP: state_in = ST_SHAPE;
         ST_SHAPE: state_in = last_motor ? ST_DONE : ST_ERR;
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         ST_IDLE:  ctrl.accept = req_valid;
         ST_ERR:   ctrl.load_err = 1'b1;
         ST_DIV:   ctrl.div_step = 1'b1;
         ST_SCALE: ctrl.load_scale = 1'b1;
         ST_RECIP: ctrl.recip = 1'b1;
         ST_SHAPE: ctrl.shape = 1'b1;
         ST_DONE:  ctrl.finish = !rsp_valid_ff || !rsp_stall;
         default:  ctrl = '0;
      endcase
   end

   assign last_motor = (motor_ff == MOT_W'(NUM_MOTORS - 1));
   assign last_step  = (cnt_ff == CNT_W'(DRV_W - 1));

   // ramp error and divisor
   assign cur_target = target_ff[motor_ff];
   assign cur_drive  = drive_ff[motor_ff];
   assign err        = {cur_target[DRV_W-1], cur_target} - {cur_drive[DRV_W-1], cur_drive};
   assign err_mag    = err[DRV_W] ? DRV_W'(-err) : err[DRV_W-1:0];
   assign div_eff    = (ramp_div_ff == '0) ? DIV_W'(1) : ramp_div_ff;

   // one restoring divide step
   assign rem_sh = {rem_ff, quo_ff[DRV_W-1]};
   assign fits   = (rem_sh >= {1'b0, dsor_ff});
   assign rem_nx = fits ? DIV_W'(rem_sh - {1'b0, dsor_ff}) : rem_sh[DIV_W-1:0];

   // drive update and balance product
   assign delta     = neg_ff ? (DRV_W+1)'(-{1'b0, quo_ff}) : {1'b0, quo_ff};
   assign new_sum   = {cur_drive[DRV_W-1], cur_drive} + delta;
   assign new_drive = new_sum[DRV_W-1:0];
   assign new_abs   = new_drive[DRV_W-1] ? DRV_W'(-new_drive) : new_drive;
   assign product   = PROD_W'(new_abs) * PROD_W'(bal_ff[motor_ff]);

   // clamp, dead band, minimum drive and duty
   assign mag_c   = (quo_ff > MAG_FULL) ? MAG_FULL : quo_ff;
   assign mag_s   = (mag_c <= MAG_ONE) ? '0 : ((mag_c < MAG_LOW) ? MAG_LOW : mag_c);
   assign neg_s   = neg_ff && (mag_s != '0);
   assign duty_s  = duty_of(mag_s[FRAC_BITS+PCT_W-1:FRAC_BITS]);
   assign level_s = INVERT_MASK[motor_ff] ? neg_s : !neg_s;

   assign bal_wr = (csr_wdata[BAL_W-1:0] > BAL_W'(PCT_FULL)) ? BAL_W'(PCT_FULL)
                                                            : csr_wdata[BAL_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         motor_ff     <= '0;
         cnt_ff       <= '0;
         ramp_div_ff  <= DIV_W'(DIV_RESET);
         for (int i = 0; i < NUM_MOTORS; i++) begin
            drive_ff[i] <= '0;
            bal_ff[i]   <= BAL_W'(PCT_FULL);
         end
      end else begin
         state_ff <= state_in;
         if (ctrl.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (ctrl.accept) begin
            motor_ff <= '0;
         end else if (ctrl.shape) begin
            motor_ff <= motor_ff + MOT_W'(1);
         end
         if (ctrl.load_err) begin
            cnt_ff <= '0;
         end else if (ctrl.div_step) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         if (ctrl.load_scale) begin
            drive_ff[motor_ff] <= new_drive;
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_RAMP_DIVISOR:  ramp_div_ff <= csr_wdata;
               CSR_BALANCE_ONE:   bal_ff[0]   <= bal_wr;
               CSR_BALANCE_TWO:   bal_ff[1]   <= bal_wr;
               CSR_BALANCE_THREE: bal_ff[2]   <= bal_wr;
               CSR_BALANCE_FOUR:  bal_ff[3]   <= bal_wr;
               default: ;
            endcase
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         target_ff[0] <= req_target_one;
         target_ff[1] <= req_target_two;
         target_ff[2] <= req_target_three;
         target_ff[3] <= req_target_four;
      end
      if (ctrl.load_err) begin
         neg_ff  <= err[DRV_W];
         quo_ff  <= err_mag;
         rem_ff  <= '0;
         dsor_ff <= div_eff;
      end else if (ctrl.load_scale) begin
         neg_ff  <= new_drive[DRV_W-1];
         prod_ff <= product;
      end else if (ctrl.recip) begin
         quo_ff <= div_by_pct(prod_ff);
      end else if (ctrl.div_step) begin
         quo_ff <= {quo_ff[DRV_W-2:0], fits};
         rem_ff <= rem_nx;
      end
      if (ctrl.shape) begin
         dir_ff[motor_ff]  <= level_s;
         duty_ff[motor_ff] <= duty_s;
      end
      if (ctrl.finish) begin
         rsp_dir_ff  <= dir_ff;
         rsp_duty_ff <= duty_ff;
      end
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_dir_one    = rsp_dir_ff[0];
   assign rsp_duty_one   = rsp_duty_ff[0];
   assign rsp_dir_two    = rsp_dir_ff[1];
   assign rsp_duty_two   = rsp_duty_ff[1];
   assign rsp_dir_three  = rsp_dir_ff[2];
   assign rsp_duty_three = rsp_duty_ff[2];
   assign rsp_dir_four   = rsp_dir_ff[3];
   assign rsp_duty_four  = rsp_duty_ff[3];

endmodule

[tb/tb_top.sv]
// testbench for the four-motor ramp pwm drive: directed table and random ramps against a predictor
`timescale 1ns / 1ps

module tb_top;
   import fmrpd_pkg::*;

   localparam int CLK_HALF      = 5;
   localparam int RESET_CYCLES  = 4;
   localparam int DUTY_FULL     = 255;
   localparam int IDLE_PCT      = 31;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 115;
   localparam int HOLD_CYCLES   = 1200;
   localparam int END_SLACK     = 300;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int DIV_MAX       = (1 << DIV_W) - 1;
   localparam int CSR_TOP_INDEX = (1 << CSR_IDX_W) - 1;
   localparam int FULL_Q        = PCT_FULL << FRAC_BITS;
   localparam int LOW_Q         = PCT_MIN << FRAC_BITS;
   localparam int ONE_Q         = 1 << FRAC_BITS;
   localparam int DRV_MIN       = -(1 << (DRV_W - 1));
   localparam int DRV_MAX       = (1 << (DRV_W - 1)) - 1;

   typedef logic [NUM_MOTORS-1:0][DRV_W-1:0] target_set_t;
   typedef logic [NUM_MOTORS-1:0][DIV_W-1:0] balance_set_t;

   typedef struct packed {
      logic [NUM_MOTORS-1:0]             dir;
      logic [NUM_MOTORS-1:0][DUTY_W-1:0] duty;
   } drive_beat_t;

   typedef struct packed {
      logic [DIV_W-1:0] divisor;
      balance_set_t     balance;
      target_set_t      targets;
      logic             typed;
      drive_beat_t      want;
   } stim_row_t;

   logic                    clock            = 1'b0;
   logic                    reset            = 1'b1;
   logic                    req_valid        = 1'b0;
   logic                    req_stall;
   logic signed [DRV_W-1:0] req_target_one   = '0;
   logic signed [DRV_W-1:0] req_target_two   = '0;
   logic signed [DRV_W-1:0] req_target_three = '0;
   logic signed [DRV_W-1:0] req_target_four  = '0;
   logic                    rsp_valid;
   logic                    rsp_stall        = 1'b0;
   logic                    rsp_dir_one;
   logic [DUTY_W-1:0]       rsp_duty_one;
   logic                    rsp_dir_two;
   logic [DUTY_W-1:0]       rsp_duty_two;
   logic                    rsp_dir_three;
   logic [DUTY_W-1:0]       rsp_duty_three;
   logic                    rsp_dir_four;
   logic [DUTY_W-1:0]       rsp_duty_four;
   logic                    csr_wr_en        = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index        = '0;
   logic [DIV_W-1:0]        csr_wdata        = '0;

   logic signed [DRV_W-1:0] ramp_state [NUM_MOTORS];
   logic [DIV_W-1:0]        divisor_setting;
   logic [BAL_W-1:0]        balance_setting [NUM_MOTORS];
   logic [DIV_W-1:0]        written_divisor;
   balance_set_t            written_balance;
   drive_beat_t             pending_drive [$];
   stim_row_t               directed_rows [$];
   int                      error_count   = 0;
   int                      hold_requests = 0;
   int                      holds_served  = 0;
   int                      hold_left     = 0;
   bit                      quiet         = 1'b0;

   csr_index_type balance_index [NUM_MOTORS] =
      '{CSR_BALANCE_ONE, CSR_BALANCE_TWO, CSR_BALANCE_THREE, CSR_BALANCE_FOUR};
   string motor_name [NUM_MOTORS] = '{"one", "two", "three", "four"};

   four_motor_ramp_pwm_drive dut (.*);

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   task automatic report_error(input string msg);
      error_count++;
      $display("%0t ERROR: %s", $time, msg);
   endtask

   function automatic drive_beat_t ramp_and_shape(input target_set_t tgt);
      drive_beat_t beat;
      int          step_div, drive, scaled, mag, i;
      logic        neg;
      step_div = (divisor_setting == 0) ? 1 : int'(divisor_setting);
      for (i = 0; i < NUM_MOTORS; i++) begin
         drive = int'(ramp_state[i]);
         drive = drive + (int'(signed'(tgt[i])) - drive) / step_div;
         ramp_state[i] = DRV_W'(drive);
         scaled = drive * int'(balance_setting[i]) / PCT_FULL;
         if (scaled > FULL_Q) scaled = FULL_Q;
         if (scaled < -FULL_Q) scaled = -FULL_Q;
         neg = scaled < 0;
         mag = neg ? -scaled : scaled;
         if (mag <= ONE_Q) begin
            mag = 0;
         end else if (mag < LOW_Q) begin
            mag = LOW_Q;
         end
         if (mag == 0) neg = 1'b0;
         beat.duty[i] = DUTY_W'((mag >> FRAC_BITS) * DUTY_FULL / PCT_FULL);
         beat.dir[i]  = INVERT_MASK[i] ? neg : !neg;
      end
      return beat;
   endfunction

   function automatic logic [DRV_W-1:0] new_target();
      int value;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: value = int'($urandom_range(0, (1 << DRV_W) - 1)) + DRV_MIN;
         4, 5, 6: value = int'($urandom_range(0, 2 * FULL_Q)) - FULL_Q;
         7: begin
            case ($urandom_range(0, 2))
               0: value = ONE_Q;
               1: value = LOW_Q;
               default: value = FULL_Q;
            endcase
            value = value + int'($urandom_range(0, 4)) - 2;
            if ($urandom_range(0, 1) == 1) value = -value;
         end
         8: begin
            case ($urandom_range(0, 2))
               0: value = DRV_MIN;
               1: value = DRV_MAX;
               default: value = 0;
            endcase
         end
         default: value = int'($urandom_range(0, 2 * LOW_Q)) - LOW_Q;
      endcase
      return DRV_W'(value);
   endfunction

   function automatic void add_row(input int divisor, b1, b2, b3, b4, t1, t2, t3, t4,
                                   input logic typed, input logic [NUM_MOTORS-1:0] dirs,
                                   input int u1, u2, u3, u4);
      stim_row_t row;
      row.divisor   = DIV_W'(divisor);
      row.balance   = {DIV_W'(b4), DIV_W'(b3), DIV_W'(b2), DIV_W'(b1)};
      row.targets   = {DRV_W'(t4), DRV_W'(t3), DRV_W'(t2), DRV_W'(t1)};
      row.typed     = typed;
      row.want.dir  = dirs;
      row.want.duty = {DUTY_W'(u4), DUTY_W'(u3), DUTY_W'(u2), DUTY_W'(u1)};
      directed_rows.push_back(row);
   endfunction

   task automatic send_targets(input target_set_t tgt, input logic typed,
                               input drive_beat_t want);
      drive_beat_t predicted;
      if (!quiet) begin
         while ($urandom_range(0, 99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid        <= 1'b1;
      req_target_one   <= tgt[0];
      req_target_two   <= tgt[1];
      req_target_three <= tgt[2];
      req_target_four  <= tgt[3];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = ramp_and_shape(tgt);
      pending_drive.push_back(typed ? want : predicted);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_drive.size() != 0) @(posedge clock);
   endtask

   task automatic write_settings(input logic [DIV_W-1:0] divisor, input balance_set_t balance);
      int i;
      csr_wr_en <= 1'b1;
      csr_index <= CSR_RAMP_DIVISOR;
      csr_wdata <= divisor;
      @(posedge clock);
      divisor_setting = divisor;
      for (i = 0; i < NUM_MOTORS; i++) begin
         csr_index <= balance_index[i];
         csr_wdata <= balance[i];
         @(posedge clock);
         balance_setting[i] = (balance[i][BAL_W-1:0] > PCT_FULL) ? BAL_W'(PCT_FULL)
                                                                  : balance[i][BAL_W-1:0];
      end
      // unmapped index leaves every setting alone
      csr_index <= CSR_IDX_W'($urandom_range(NUM_MOTORS + 1, CSR_TOP_INDEX));
      csr_wdata <= DIV_W'($urandom_range(0, DIV_MAX));
      @(posedge clock);
      csr_wr_en       <= 1'b0;
      written_divisor = divisor;
      written_balance = balance;
   endtask

   always @(posedge clock) begin : result_stall
      if (holds_served != hold_requests) begin
         holds_served = hold_requests;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   always @(posedge clock) begin : result_check
      drive_beat_t got, want;
      int          i;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.dir  = {rsp_dir_four, rsp_dir_three, rsp_dir_two, rsp_dir_one};
         got.duty = {rsp_duty_four, rsp_duty_three, rsp_duty_two, rsp_duty_one};
         if (pending_drive.size() == 0) begin
            report_error($sformatf("result beat with nothing expected: %h", got));
         end else begin
            want = pending_drive.pop_front();
            for (i = 0; i < NUM_MOTORS; i++) begin
               if (got.dir[i] !== want.dir[i])
                  report_error($sformatf("dir_%s got %0d expected %0d",
                                         motor_name[i], got.dir[i], want.dir[i]));
               if (got.duty[i] !== want.duty[i])
                  report_error($sformatf("duty_%s got %0d expected %0d",
                                         motor_name[i], got.duty[i], want.duty[i]));
            end
         end
      end
   end

   initial begin : stimulus
      stim_row_t        row;
      target_set_t      tgt;
      balance_set_t     bal;
      logic [DIV_W-1:0] divisor;
      int               phase, item, m, r;

      for (m = 0; m < NUM_MOTORS; m++) begin
         ramp_state[m]      = '0;
         balance_setting[m] = BAL_W'(PCT_FULL);
         written_balance[m] = DIV_W'(PCT_FULL);
      end
      divisor_setting = DIV_W'(DIV_RESET);
      written_divisor = DIV_W'(DIV_RESET);

      // reset settings, drive at rest
      add_row(10, 100, 100, 100, 100, 0, 0, 0, 0, 1'b1, 4'b1001, 0, 0, 0, 0);
      add_row(10, 100, 100, 100, 100, 25600, -25600, 12800, -12800, 1'b0, '0, 0, 0, 0, 0);
      add_row(10, 100, 100, 100, 100, 32767, -32768, -1, 1, 1'b0, '0, 0, 0, 0, 0);
      // zero divisor jumps straight to the target
      add_row(0, 100, 100, 100, 100, 25600, -25600, 25600, -25600,
              1'b1, 4'b0011, 255, 255, 255, 255);
      add_row(0, 100, 100, 100, 100, 32767, -32768, -32768, 32767,
              1'b1, 4'b1111, 255, 255, 255, 255);
      add_row(0, 100, 100, 100, 100, 256, -256, 257, -257, 1'b1, 4'b0001, 0, 0, 38, 38);
      add_row(0, 100, 100, 100, 100, 3839, -3840, 3841, 0, 1'b1, 4'b1011, 38, 38, 38, 0);
      add_row(0, 100, 100, 100, 100, 12800, -12800, 25599, 1,
              1'b1, 4'b1011, 127, 127, 252, 0);
      add_row(0, 100, 100, 100, 100, -1, 255, -255, 258, 1'b1, 4'b1001, 0, 0, 0, 38);
      // balance extremes, a write above 100 clamps
      add_row(1, 0, 50, 100, 255, 25600, 25600, -25600, -25600,
              1'b1, 4'b0101, 0, 127, 255, 255);
      add_row(1, 0, 50, 100, 255, -32768, 32767, 5120, -5121,
              1'b1, 4'b0001, 0, 160, 51, 51);
      add_row(255, 100, 100, 100, 100, 25600, -25600, 32767, -32768, 1'b0, '0, 0, 0, 0, 0);
      add_row(255, 100, 100, 100, 100, 25600, -25600, 32767, -32768, 1'b0, '0, 0, 0, 0, 0);
      add_row(3, 37, 99, 1, 128, -7000, 9000, 25600, -20000, 1'b0, '0, 0, 0, 0, 0);
      add_row(3, 37, 99, 1, 128, -7000, 9000, 25600, -20000, 1'b0, '0, 0, 0, 0, 0);
      add_row(3, 37, 99, 1, 128, 4000, -300, -25600, 700, 1'b0, '0, 0, 0, 0, 0);
      add_row(10, 100, 100, 100, 100, 0, 0, 0, 0, 1'b0, '0, 0, 0, 0, 0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (r = 0; r < directed_rows.size(); r++) begin
         row = directed_rows[r];
         if (row.divisor != written_divisor || row.balance != written_balance) begin
            wait_for_results();
            write_settings(row.divisor, row.balance);
         end
         send_targets(row.targets, row.typed, row.want);
      end

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_for_results();
         case (phase)
            0: begin
               divisor = DIV_W'(1);
               for (m = 0; m < NUM_MOTORS; m++) bal[m] = DIV_W'($urandom_range(0, DIV_MAX));
            end
            1: begin
               divisor = DIV_W'(DIV_MAX);
               for (m = 0; m < NUM_MOTORS; m++) bal[m] = DIV_W'(PCT_FULL);
            end
            2: begin
               divisor = '0;
               bal     = {DIV_W'(DIV_MAX), DIV_W'(127), DIV_W'(PCT_FULL), DIV_W'(0)};
            end
            default: begin
               divisor = ($urandom_range(0, 2) == 0) ? DIV_W'($urandom_range(0, DIV_MAX))
                                                     : DIV_W'($urandom_range(1, 16));
               for (m = 0; m < NUM_MOTORS; m++)
                  bal[m] = ($urandom_range(0, 1) == 1) ? DIV_W'($urandom_range(0, DIV_MAX))
                                                       : DIV_W'($urandom_range(60, PCT_FULL));
            end
         endcase
         write_settings(divisor, bal);
         quiet = (phase == 3);
         for (m = 0; m < NUM_MOTORS; m++) tgt[m] = new_target();
         for (item = 0; item < PHASE_ITEMS; item++) begin
            // targets hold for a few beats so the ramp gets somewhere
            for (m = 0; m < NUM_MOTORS; m++)
               if ($urandom_range(0, 3) == 0) tgt[m] = new_target();
            if (phase == 5 && item == 40) hold_requests++;
            if (phase == 6 && item == 50) wait_for_results();
            send_targets(tgt, 1'b0, '0);
         end
      end
      quiet = 1'b0;

      wait_for_results();
      repeat (END_SLACK) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
